@@ hdl/huffman_bit_packing_encoder_macros.svh @@
// assertion macros shared by the encoder modules
`ifndef HUFFMAN_BIT_PACKING_ENCODER_MACROS_SVH
`define HUFFMAN_BIT_PACKING_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define HBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbpe assertion failed");
`define HBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbpe assertion failed");
`else
`define HBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/hbpe_pkg.sv @@
`default_nettype none
package hbpe_pkg;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int Q_DEPTH = 4;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_BAD,
    KIND_FLUSH
  } kind_t;

  // code is left-aligned: first code bit in the top bit
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } q_entry_t;
endpackage
`default_nettype wire

@@ hdl/hbpe_front.sv @@
`default_nettype none
`include "huffman_bit_packing_encoder_macros.svh"
module hbpe_front #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [7:0]                     in_symbol,
  input  wire logic [hbpe_pkg::CODE_W-1:0]    in_code_bits,
  input  wire logic [hbpe_pkg::LEN_W-1:0]     in_code_length,
  input  wire logic                           q_full,
  output logic                                q_push,
  output hbpe_pkg::q_entry_t                  q_entry
);
  import hbpe_pkg::*;

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int LEN_CAP = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;

  logic [SYMBOL_COUNT-1:0]   valid_r;
  logic [CODE_W+LEN_W-1:0]   code_mem [SYMBOL_COUNT];
  logic [CODE_W+LEN_W-1:0]   rd_data_r;
  logic                      err_r, err_nxt;
  logic                      s1_vld_r, s1_vld_nxt;
  kind_t                     s1_kind_r, s1_kind_nxt;
  logic [IDX_W-1:0]          idx;
  logic                      in_range, hit, advance, accept, wr_en, rd_en;
  logic [LEN_W-1:0]          len_sat;
  logic [CODE_W-1:0]         code_left;

  assign idx      = in_symbol[IDX_W-1:0];
  assign in_range = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);
  assign hit      = in_range && valid_r[idx];
  assign advance  = !s1_vld_r || !q_full;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign wr_en    = accept && (in_action == ACT_LOAD) && in_range;
  assign rd_en    = accept && (in_action == ACT_ENCODE) && !err_r && hit;

  assign len_sat   = (in_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_code_length;
  // bits above the length fall off the top
  assign code_left = in_code_bits << (LEN_W'(CODE_W) - len_sat);

  assign q_push  = s1_vld_r && !q_full;
  assign q_entry = {s1_kind_r, rd_data_r};

  always_comb begin
    err_nxt     = err_r;
    s1_vld_nxt  = s1_vld_r;
    s1_kind_nxt = s1_kind_r;
    if (advance) begin
      s1_vld_nxt = 1'b0;
      if (in_valid) begin
        unique case (in_action)
          ACT_ENCODE: begin
            if (!err_r) begin
              s1_vld_nxt  = 1'b1;
              s1_kind_nxt = hit ? KIND_DATA : KIND_BAD;
              err_nxt     = !hit;
            end
          end
          ACT_FLUSH: begin
            s1_vld_nxt  = 1'b1;
            s1_kind_nxt = KIND_FLUSH;
            err_nxt     = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      err_r     <= 1'b0;
      s1_vld_r  <= 1'b0;
      s1_kind_r <= KIND_DATA;
    end else begin
      err_r     <= err_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s1_kind_r <= s1_kind_nxt;
      if (wr_en) begin
        valid_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[idx] <= {len_sat, code_left};
    end
    if (rd_en) begin
      rd_data_r <= code_mem[idx];
    end
  end

  `HBPE_ASSERT_IMP(a_bad_sets_err, clk, rst_n, s1_vld_r && s1_kind_r == KIND_BAD, err_r)
endmodule
`default_nettype wire

@@ hdl/hbpe_queue.sv @@
`default_nettype none
`include "huffman_bit_packing_encoder_macros.svh"
module hbpe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hbpe_pkg::q_entry_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output hbpe_pkg::q_entry_t      head
);
  import hbpe_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         slots_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_W'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `HBPE_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !full)
  `HBPE_ASSERT_IMP(a_q_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(Q_DEPTH))
endmodule
`default_nettype wire

@@ hdl/hbpe_back.sv @@
`default_nettype none
`include "huffman_bit_packing_encoder_macros.svh"
module hbpe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire hbpe_pkg::q_entry_t q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_is_header,
  output logic                    out_bad_symbol,
  output logic                    out_last
);
  import hbpe_pkg::*;

  localparam int WIN_W = CODE_W + 8;
  localparam int TOT_W = LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTES,
    ST_HDR
  } state_t;

  state_t           state_r, state_nxt;
  logic [6:0]       pend_r, pend_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             is_header_r, is_header_nxt;
  logic             bad_r, bad_nxt;
  logic             last_r, last_nxt;

  logic             slot_free, pop, win_emit;
  logic [WIN_W-1:0] win_new, src_win, win_sh;
  logic [TOT_W-1:0] tot_new, src_tot, rem;

  assign slot_free = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && !q_empty && slot_free;
  assign q_pop     = pop;

  // pending bits on top, code bits right behind them
  assign win_new = {pend_r, 1'b0, {CODE_W{1'b0}}}
                 | (WIN_W'(q_head.code) << (4'd8 - {1'b0, cnt_r}));
  assign tot_new = TOT_W'(cnt_r) + q_head.len;

  assign src_win  = (state_r == ST_BYTES) ? win_r : win_new;
  assign src_tot  = (state_r == ST_BYTES) ? tot_r : tot_new;
  assign win_sh   = src_win << 8;
  assign rem      = src_tot - TOT_W'(8);
  assign win_emit = (state_r == ST_BYTES && slot_free)
                 || (pop && q_head.kind == KIND_DATA && tot_new >= TOT_W'(8));

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    win_nxt       = win_r;
    tot_nxt       = tot_r;
    hdr_nxt       = hdr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    is_header_nxt = is_header_r;
    bad_nxt       = bad_r;
    last_nxt      = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (q_head.kind)
            KIND_DATA: begin
              if (tot_new < TOT_W'(8)) begin
                pend_nxt = win_new[WIN_W-1 -: 7];
                cnt_nxt  = tot_new[2:0];
              end
            end
            KIND_BAD: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = 8'd0;
              is_header_nxt = 1'b0;
              bad_nxt       = 1'b1;
              last_nxt      = 1'b1;
            end
            KIND_FLUSH: begin
              pend_nxt      = '0;
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
              bad_nxt       = 1'b0;
              if (cnt_r != 3'd0) begin
                out_byte_nxt  = {pend_r, 1'b0};
                is_header_nxt = 1'b0;
                last_nxt      = 1'b0;
                hdr_nxt       = 8'h80 >> cnt_r;
                state_nxt     = ST_HDR;
              end else begin
                out_byte_nxt  = 8'd0;
                is_header_nxt = 1'b1;
                last_nxt      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BYTES: begin
      end
      ST_HDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hdr_r;
          is_header_nxt = 1'b1;
          bad_nxt       = 1'b0;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (win_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = src_win[WIN_W-1 -: 8];
      is_header_nxt = 1'b0;
      bad_nxt       = 1'b0;
      last_nxt      = rem < TOT_W'(8);
      if (rem < TOT_W'(8)) begin
        pend_nxt  = win_sh[WIN_W-1 -: 7];
        cnt_nxt   = rem[2:0];
        state_nxt = ST_IDLE;
      end else begin
        win_nxt   = win_sh;
        tot_nxt   = rem;
        state_nxt = ST_BYTES;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    win_r       <= win_nxt;
    tot_r       <= tot_nxt;
    hdr_r       <= hdr_nxt;
    out_byte_r  <= out_byte_nxt;
    is_header_r <= is_header_nxt;
    bad_r       <= bad_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_header  = is_header_r;
  assign out_bad_symbol = bad_r;
  assign out_last       = last_r;

  `HBPE_ASSERT_IMP(a_pend_aligned, clk, rst_n, 1'b1, (pend_r << cnt_r) == 7'd0)
  `HBPE_ASSERT_IMP(a_bytes_left, clk, rst_n, state_r == ST_BYTES, tot_r >= TOT_W'(8))
  `HBPE_ASSERT_NXT(a_flush_hdr, clk, rst_n, pop && q_head.kind == KIND_FLUSH && cnt_r != 3'd0, state_r == ST_HDR)
endmodule
`default_nettype wire

@@ hdl/huffman_bit_packing_encoder.sv @@
// an accepted input word passes the front stage register, a queue slot and the packer's
// output register before its first result is on out_valid; throughput: one input word per
// cycle into a four-entry queue while in_ready is high; the packer emits one byte per cycle
// while out_ready allows it and pops no new entry until the current one's bytes are all out
// reset: rst_n low clears the valid marks, pending bits, error flag, queue and output;
// the code store keeps its contents and is only read where its valid mark is set
`default_nettype none
module huffman_bit_packing_encoder #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_action,
  input  wire logic [7:0]                  in_symbol,
  input  wire logic [hbpe_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hbpe_pkg::LEN_W-1:0]  in_code_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_is_header,
  output logic                             out_bad_symbol,
  output logic                             out_last
);
  import hbpe_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_entry, q_head;

  hbpe_front #(
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  hbpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  hbpe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_header  (out_is_header),
    .out_bad_symbol (out_bad_symbol),
    .out_last       (out_last)
  );
endmodule
`default_nettype wire
